### hw/rtl/tfkc_pkg.sv
// ----------------------------------------------------------------------------
// tfkc_pkg
// Shared types and constants of the TTL key cache: field widths, register
// indexes, operation codes and the sequencer's state types.
// ----------------------------------------------------------------------------
`default_nettype none

package tfkc_pkg;

	localparam int KEY_IN_W = 16;
	localparam int TIME_W   = 32;
	localparam int OCC_W    = 5;
	localparam int MAX_W    = 5;
	localparam int CFG_AW   = 2;
	localparam int CFG_DW   = 32;
	localparam int IN_DW    = 48;
	localparam int OUT_DW   = 8;

	localparam logic [CFG_AW-1:0] CFG_ENABLE = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_MAX    = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_TTL    = 2'd2;

	localparam logic [MAX_W-1:0]  MAX_RESET    = 5'd16;
	localparam logic [TIME_W-1:0] TTL_RESET    = 32'd1000;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_STORE  = 1'b1;

	typedef enum logic [1:0] {
		WK_EXPIRE,
		WK_STORE,
		WK_NOP
	} walk_kind_t;

	typedef enum logic [1:0] {
		WM_EXPIRE,
		WM_DEDUP,
		WM_SHIFT
	} walk_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_APPEND,
		ST_REPLY
	} walk_state_t;

	typedef struct packed {
		logic       start;
		walk_kind_t kind;
		logic       reply_ok;
	} walk_ctl_t;

	typedef struct packed {
		logic             done;
		logic             hit;
		logic [OCC_W-1:0] occ;
	} walk_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/tfkc_ram.sv
// ----------------------------------------------------------------------------
// tfkc_ram
// Generic simple dual-port RAM: one write port, one read port and registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfkc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

### hw/rtl/tfkc_walk.sv
// ----------------------------------------------------------------------------
// tfkc_walk
// Entry sequencer: walks the entry RAM in insertion order, compacting it in
// place (expiry purge, same-key removal, oldest-entry eviction) and appends
// new entries.
// ----------------------------------------------------------------------------
`default_nettype none

module tfkc_walk #(
	parameter int CACHE_DEPTH = 16,
	parameter int KEY_BITS    = 16,
	parameter int CW          = $clog2(CACHE_DEPTH + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tfkc_pkg::walk_ctl_t         ctl,
	input  wire logic [KEY_BITS-1:0]         key,
	input  wire logic [tfkc_pkg::TIME_W-1:0] tm,
	input  wire logic [CW-1:0]               cap,
	output tfkc_pkg::walk_rsp_t              rsp
);

	import tfkc_pkg::*;

	localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int RW = KEY_BITS + TIME_W;

	walk_state_t         state_q, state_d;
	walk_mode_t          mode_q;
	logic [CW-1:0]       rd_ptr_q, wr_ptr_q, count_q, cap_q;
	logic                pend_s1;
	logic                hit_q;
	logic [KEY_BITS-1:0] key_q;
	logic [TIME_W-1:0]   tm_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [RW-1:0]       ram_wdata, ram_rdata;
	logic [KEY_BITS-1:0] rd_key;
	logic [TIME_W-1:0]   rd_exp;
	logic                rd_more, walk_done, keep;
	logic [CW+OCC_W-1:0] count_ext;

	assign rd_key    = ram_rdata[RW-1:TIME_W];
	assign rd_exp    = ram_rdata[TIME_W-1:0];
	assign rd_more   = rd_ptr_q < count_q;
	assign walk_done = (state_q == ST_WALK) && !rd_more && !pend_s1;
	assign count_ext = {{OCC_W{1'b0}}, count_q};

	always_comb begin
		case (mode_q)
			WM_EXPIRE: keep = rd_exp > tm_q;
			WM_DEDUP:  keep = rd_key != key_q;
			WM_SHIFT:  keep = 1'b1;
			default:   keep = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					state_d = (ctl.kind == WK_NOP) ? ST_REPLY : ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_done) begin
					case (mode_q)
						WM_EXPIRE: state_d = ST_REPLY;
						WM_DEDUP:  state_d = (wr_ptr_q >= cap_q) ? ST_WALK : ST_APPEND;
						WM_SHIFT:  state_d = ST_APPEND;
						default:   state_d = ST_REPLY;
					endcase
				end
			end
			ST_APPEND: state_d = ST_REPLY;
			ST_REPLY: begin
				if (ctl.reply_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: RAM write port and reply
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_ptr_q[AW-1:0];
		ram_wdata = ram_rdata;
		rsp.done  = 1'b0;
		rsp.hit   = hit_q;
		rsp.occ   = count_ext[OCC_W-1:0];
		case (state_q)
			ST_WALK: begin
				ram_we = pend_s1 && keep;
			end
			ST_APPEND: begin
				ram_we    = 1'b1;
				ram_wdata = {key_q, tm_q};
			end
			ST_REPLY: begin
				rsp.done = ctl.reply_ok;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= WM_EXPIRE;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			pend_s1  <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == ST_WALK) && rd_more;
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						mode_q   <= (ctl.kind == WK_EXPIRE) ? WM_EXPIRE : WM_DEDUP;
						rd_ptr_q <= '0;
						wr_ptr_q <= '0;
						hit_q    <= 1'b0;
					end
				end
				ST_WALK: begin
					if (rd_more) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					if (pend_s1 && keep) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
						if (mode_q == WM_EXPIRE && rd_key == key_q) begin
							hit_q <= 1'b1;
						end
					end
					if (walk_done) begin
						count_q <= wr_ptr_q;
						// evict oldest survivors so that the new entry fits
						if (mode_q == WM_DEDUP && wr_ptr_q >= cap_q) begin
							mode_q   <= WM_SHIFT;
							rd_ptr_q <= wr_ptr_q - cap_q + 1'b1;
							wr_ptr_q <= '0;
						end
					end
				end
				ST_APPEND: begin
					count_q <= wr_ptr_q + 1'b1;
				end
				default: begin
					hit_q <= hit_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && ctl.start) begin
			key_q <= key;
			tm_q  <= tm;
			cap_q <= cap;
		end
	end

	tfkc_ram #(
		.WIDTH (RW),
		.DEPTH (CACHE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (rd_ptr_q[AW-1:0]),
		.rd_data (ram_rdata)
	);

	// compaction writes never overtake the read pointer
	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && pend_s1) |-> (wr_ptr_q < rd_ptr_q))
		else $error("write pointer reached read pointer");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CACHE_DEPTH))
		else $error("entry count above depth");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPEND) |-> (wr_ptr_q < cap_q))
		else $error("append with no room below capacity");

	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (ctl.reply_ok && state_q == ST_REPLY))
		else $error("reply issued with output slot busy");

endmodule

`default_nettype wire

### hw/rtl/ttl_fifo_key_cache.sv
// ----------------------------------------------------------------------------
// ttl_fifo_key_cache
// Key-only cache with time-to-live expiry, held as an insertion-ordered list
// of (key, expiry) pairs in one RAM.
//
//   channel  | dir | handshake                   | payload
//   ---------+-----+-----------------------------+------------------------------
//   s_axis   | in  | s_axis_tvalid/s_axis_tready | tdata key,now; tuser operation
//   m_axis   | out | m_axis_tvalid/m_axis_tready | tdata hit,occupancy
//   cfg      | in  | cfg_we                      | cfg_addr, cfg_wdata
//
// A lookup reads each of the n entries held once from the RAM, then replies;
// an enabled store walks them the same way and then appends, after a second
// pass when surviving entries must be shifted down to evict the oldest. The single
// read port of the entry RAM sets this pace; one item is in work at a time.
// The next word is accepted while a result still waits on m_axis.
// Reset empties the cache at once (entry count cleared, no RAM pass).
// ----------------------------------------------------------------------------
`default_nettype none

module ttl_fifo_key_cache #(
	parameter int CACHE_DEPTH = 16,
	parameter int KEY_BITS    = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [tfkc_pkg::IN_DW-1:0]  s_axis_tdata,   // key[15:0], now[47:16]
	input  wire logic                        s_axis_tuser,   // operation
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic      [tfkc_pkg::OUT_DW-1:0] m_axis_tdata,   // hit[0], occupancy[5:1]
	input  wire logic                        cfg_we,
	input  wire logic [tfkc_pkg::CFG_AW-1:0] cfg_addr,
	input  wire logic [tfkc_pkg::CFG_DW-1:0] cfg_wdata
);

	import tfkc_pkg::*;

	localparam int CW = $clog2(CACHE_DEPTH + 1);

	logic                    en_q;
	logic [MAX_W-1:0]        max_q;
	logic [TIME_W-1:0]       ttl_q;
	logic                    busy_q;
	logic                    start_s1;
	walk_kind_t              kind_s1;
	logic [KEY_BITS-1:0]     key_s1;
	logic [TIME_W-1:0]       tm_s1;
	logic                    out_valid_q;
	logic                    out_hit_q;
	logic [OCC_W-1:0]        out_occ_q;

	logic                    in_acc;
	logic [KEY_IN_W-1:0]     in_key;
	logic [TIME_W-1:0]       in_now;
	logic [KEY_BITS+KEY_IN_W-1:0] key_ext;
	logic [TIME_W:0]         exp_sum;
	logic [TIME_W-1:0]       exp_sat;
	logic [CW-1:0]           cap;
	walk_ctl_t               ctl;
	walk_rsp_t               rsp;

	assign in_key  = s_axis_tdata[KEY_IN_W-1:0];
	assign in_now  = s_axis_tdata[KEY_IN_W+TIME_W-1:KEY_IN_W];
	assign key_ext = {{KEY_BITS{1'b0}}, in_key};
	assign exp_sum = {1'b0, in_now} + {1'b0, ttl_q};
	assign exp_sat = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];

	assign s_axis_tready = !busy_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// clamp capacity into 1 .. depth
	always_comb begin
		if (max_q == '0) begin
			cap = CW'(1);
		end else if (int'(max_q) > CACHE_DEPTH) begin
			cap = CW'(CACHE_DEPTH);
		end else begin
			cap = CW'(max_q);
		end
	end

	assign ctl.start    = start_s1;
	assign ctl.kind     = kind_s1;
	assign ctl.reply_ok = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b1;
			max_q <= MAX_RESET;
			ttl_q <= TTL_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ENABLE: en_q  <= cfg_wdata[0];
				CFG_MAX:    max_q <= cfg_wdata[MAX_W-1:0];
				CFG_TTL:    ttl_q <= cfg_wdata[TIME_W-1:0];
				default:    en_q  <= en_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_s1    <= 1'b0;
			kind_s1     <= WK_NOP;
			out_valid_q <= 1'b0;
		end else begin
			start_s1 <= in_acc;
			if (in_acc) begin
				busy_q <= 1'b1;
				if (s_axis_tuser == OP_LOOKUP) begin
					kind_s1 <= WK_EXPIRE;
				end else begin
					kind_s1 <= en_q ? WK_STORE : WK_NOP;
				end
			end else if (rsp.done) begin
				busy_q <= 1'b0;
			end
			if (rsp.done) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_s1 <= key_ext[KEY_BITS-1:0];
			tm_s1  <= (s_axis_tuser == OP_STORE) ? exp_sat : in_now;
		end
		if (rsp.done) begin
			out_hit_q <= rsp.hit;
			out_occ_q <= rsp.occ;
		end
	end

	tfkc_walk #(
		.CACHE_DEPTH (CACHE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.CW          (CW)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.key    (key_s1),
		.tm     (tm_s1),
		.cap    (cap),
		.rsp    (rsp)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DW-OCC_W-1){1'b0}}, out_occ_q, out_hit_q};

	// one result per accepted word: never accept while an item is in work
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("second word accepted while busy");

	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> busy_q)
		else $error("reply without an item in work");

	a_store_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.done && kind_s1 != WK_EXPIRE) |-> !rsp.hit)
		else $error("store reported a hit");

endmodule

`default_nettype wire

### test/ttl_fifo_key_cache_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttl_fifo_key_cache_test
// Self-checking bench for the TTL key cache. A short scripted sequence hits
// the empty cache, expiry at the boundary, saturated expiry, duplicate keys,
// disabled stores and out-of-range capacities. Then ten phases of random
// lookups and stores run under different register settings. Each result is
// checked against its typed script row or a software copy of the list.
// ----------------------------------------------------------------------------

module ttl_fifo_key_cache_test;
	import tfkc_pkg::*;

	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 65;
	localparam int POOL_SIZE   = 24;
	localparam int SCRIPT_ROWS = 31;
	localparam int DUE_DEPTH   = 8;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [CFG_AW-1:0]   reg_idx;
		logic                op;
		logic [KEY_IN_W-1:0] key;
		logic [TIME_W-1:0]   val;
		logic                typed;
		logic                hit;
		logic [OCC_W-1:0]    occ;
	} row_t;

	typedef struct packed {
		logic             hit;
		logic [OCC_W-1:0] occ;
	} reply_t;

	// Word rows carry now in val; register rows carry the write data in val.
	// typed = 1 means the expected hit/occupancy are given in the row.
	row_t script [0:SCRIPT_ROWS-1] = '{
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'h0000, 32'h00000000, 1'b1, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'hFFFF, 32'h00000000, 1'b1, 1'b0, 5'd1},
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'hFFFF, 32'd999,      1'b1, 1'b1, 5'd1},
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'hFFFF, 32'd1000,     1'b1, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h0000, 32'hFFFFFFFF, 1'b1, 1'b0, 5'd1},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h1234, 32'hFFFFFC18, 1'b1, 1'b0, 5'd2},
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'h0000, 32'hFFFFFFFE, 1'b1, 1'b1, 5'd2},
		// time steps back; the duplicate key is replaced, not added
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h1234, 32'd5,        1'b1, 1'b0, 5'd2},
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'h1234, 32'd6,        1'b1, 1'b1, 5'd2},
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'h5555, 32'hFFFFFFFF, 1'b1, 1'b0, 5'd0},
		'{ROW_REG,  CFG_ENABLE, OP_LOOKUP, 16'h0000, 32'd0,        1'b0, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'hAAAA, 32'd10,       1'b1, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'hAAAA, 32'd11,       1'b1, 1'b0, 5'd0},
		'{ROW_REG,  CFG_ENABLE, OP_LOOKUP, 16'h0000, 32'd1,        1'b0, 1'b0, 5'd0},
		// capacity zero behaves as one
		'{ROW_REG,  CFG_MAX,    OP_LOOKUP, 16'h0000, 32'd0,        1'b0, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h0001, 32'd10,       1'b1, 1'b0, 5'd1},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h0002, 32'd11,       1'b1, 1'b0, 5'd1},
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'h0001, 32'd12,       1'b1, 1'b0, 5'd1},
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'h0002, 32'd12,       1'b1, 1'b1, 5'd1},
		'{ROW_REG,  CFG_MAX,    OP_LOOKUP, 16'h0000, 32'd3,        1'b0, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h0003, 32'd20,       1'b0, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h0004, 32'd21,       1'b0, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h0005, 32'd22,       1'b0, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h0004, 32'd23,       1'b0, 1'b0, 5'd0},
		// capacity above the depth is clipped to the depth
		'{ROW_REG,  CFG_MAX,    OP_LOOKUP, 16'h0000, 32'd31,       1'b0, 1'b0, 5'd0},
		'{ROW_REG,  CFG_TTL,    OP_LOOKUP, 16'h0000, 32'hFFFFFFFF, 1'b0, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h8000, 32'd30,       1'b0, 1'b0, 5'd0},
		'{ROW_REG,  CFG_TTL,    OP_LOOKUP, 16'h0000, 32'd0,        1'b0, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_STORE,  16'h7FFF, 32'd40,       1'b0, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'h7FFF, 32'd40,       1'b0, 1'b0, 5'd0},
		'{ROW_WORD, CFG_ENABLE, OP_LOOKUP, 16'h8000, 32'd41,       1'b0, 1'b0, 5'd0}
	};

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_DW-1:0]    s_axis_tdata;   // key[15:0], now[47:16]
	logic                s_axis_tuser;   // operation
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_DW-1:0]   m_axis_tdata;   // hit[0], occupancy[5:1]
	logic                cfg_we;
	logic [CFG_AW-1:0]   cfg_addr;
	logic [CFG_DW-1:0]   cfg_wdata;

	// register copies and the cache list as the block should hold them
	logic                shadow_enable;
	logic [MAX_W-1:0]    shadow_max;
	logic [TIME_W-1:0]   shadow_ttl;
	logic [KEY_IN_W-1:0] held_key [DEPTH];
	logic [TIME_W-1:0]   held_expiry [DEPTH];
	int                  held_count;

	// expected results in order, kept as a small ring
	reply_t              replies_due [DUE_DEPTH];
	logic [2:0]          due_head;
	logic [2:0]          due_tail;
	int                  due_count;

	// expectation typed into the script for the word on the bus
	logic                word_typed;
	logic                word_hit;
	logic [OCC_W-1:0]    word_occ;

	logic                quiet;
	int                  stall_left;
	int                  errors;
	int                  lookups;
	int                  stores;
	int                  replies_seen;
	int                  hits_seen;
	int                  reg_writes;
	int                  cycles;

	ttl_fifo_key_cache dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Apply one word to the cache list and return the reply it should give.
	function automatic reply_t cache_apply(logic op, logic [KEY_IN_W-1:0] key,
			logic [TIME_W-1:0] now);
		reply_t          r;
		int              kept;
		int              cap;
		logic [TIME_W:0] sum;
		r.hit = 1'b0;
		kept = 0;
		if (op == OP_LOOKUP) begin
			// purge everything whose expiry is at or before now
			for (int i = 0; i < held_count; i++) begin
				if (held_expiry[i] > now) begin
					held_key[kept] = held_key[i];
					held_expiry[kept] = held_expiry[i];
					kept++;
				end
			end
			held_count = kept;
			for (int i = 0; i < held_count; i++)
				if (held_key[i] == key)
					r.hit = 1'b1;
		end else if (shadow_enable) begin
			cap = (shadow_max == 0) ? 1 : ((shadow_max > DEPTH) ? DEPTH : int'(shadow_max));
			sum = {1'b0, now} + {1'b0, shadow_ttl};
			for (int i = 0; i < held_count; i++) begin
				if (held_key[i] != key) begin
					held_key[kept] = held_key[i];
					held_expiry[kept] = held_expiry[i];
					kept++;
				end
			end
			held_count = kept;
			// evict oldest until there is room below the capacity
			while (held_count >= cap) begin
				for (int i = 1; i < held_count; i++) begin
					held_key[i-1] = held_key[i];
					held_expiry[i-1] = held_expiry[i];
				end
				held_count--;
			end
			held_key[held_count] = key;
			held_expiry[held_count] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
			held_count++;
		end
		r.occ = OCC_W'(held_count);
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the next call can follow back to back.
	task automatic send_word(logic op, logic [KEY_IN_W-1:0] key, logic [TIME_W-1:0] now,
			logic typed, logic hit, logic [OCC_W-1:0] occ);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tuser = op;
		s_axis_tdata = {now, key};
		word_typed = typed;
		word_hit = hit;
		word_occ = occ;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Write only with the block drained; wait for it to settle before the write.
	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
		s_axis_tvalid = 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		cfg_addr = idx;
		cfg_wdata = value;
		cfg_we = 1'b1;
		case (idx)
			CFG_ENABLE: shadow_enable = value[0];
			CFG_MAX:    shadow_max = value[MAX_W-1:0];
			CFG_TTL:    shadow_ttl = value;
			default:    ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : watch
		reply_t want;
		reply_t got;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t: no progress after %0d cycles, %0d results pending",
					$time, cycles, due_count);
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				if (m_axis_tvalid && m_axis_tready) begin
					got.hit = m_axis_tdata[0];
					got.occ = m_axis_tdata[OCC_W:1];
					replies_seen++;
					if (got.hit)
						hits_seen++;
					if (due_count == 0) begin
						$display("%0t: unexpected result word hit %0d occupancy %0d",
							$time, got.hit, got.occ);
						errors++;
					end else begin
						want = replies_due[due_head];
						due_head = due_head + 3'd1;
						due_count--;
						if (got.hit !== want.hit) begin
							$display("%0t: hit expected %0d actual %0d",
								$time, want.hit, got.hit);
							errors++;
						end
						if (got.occ !== want.occ) begin
							$display("%0t: occupancy expected %0d actual %0d",
								$time, want.occ, got.occ);
							errors++;
						end
					end
				end
				if (s_axis_tvalid && s_axis_tready) begin
					want = cache_apply(s_axis_tuser, s_axis_tdata[KEY_IN_W-1:0],
						s_axis_tdata[KEY_IN_W +: TIME_W]);
					if (word_typed) begin
						want.hit = word_hit;
						want.occ = word_occ;
					end
					replies_due[due_tail] = want;
					due_tail = due_tail + 3'd1;
					due_count++;
					if (s_axis_tuser == OP_STORE)
						stores++;
					else
						lookups++;
				end
			end
		end
	end

	initial begin
		logic [KEY_IN_W-1:0] pool [POOL_SIZE];
		logic [TIME_W:0]     t;
		logic                en;
		logic [MAX_W-1:0]    mx;
		logic [TIME_W-1:0]   ttl;
		logic                op;
		logic [KEY_IN_W-1:0] key;
		int                  roll;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_LOOKUP;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = CFG_ENABLE;
		cfg_wdata = '0;
		word_typed = 1'b0;
		word_hit = 1'b0;
		word_occ = '0;
		quiet = 1'b0;
		stall_left = 0;
		errors = 0;
		lookups = 0;
		stores = 0;
		replies_seen = 0;
		hits_seen = 0;
		reg_writes = 0;
		cycles = 0;
		due_head = '0;
		due_tail = '0;
		due_count = 0;
		shadow_enable = 1'b1;
		shadow_max = MAX_RESET;
		shadow_ttl = TTL_RESET;
		held_count = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < SCRIPT_ROWS; r++) begin
			if (script[r].kind == ROW_REG)
				write_reg(script[r].reg_idx, script[r].val);
			else
				send_word(script[r].op, script[r].key, script[r].val,
					script[r].typed, script[r].hit, script[r].occ);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			en = 1'b1;
			case (ph)
				1: begin
					mx = 5'd4;
					ttl = $urandom_range(50, 300);
					t = $urandom_range(0, 32'h0FFFFFFF);
				end
				2: begin
					mx = 5'd31;
					ttl = 32'hFFFFFFFF;
					t = $urandom();
				end
				3: begin
					en = 1'b0;
					mx = 5'd8;
					ttl = 32'd500;
					t = $urandom_range(0, 32'h7FFFFFFF);
				end
				4: begin
					mx = 5'd0;
					ttl = 32'd200;
					t = $urandom_range(0, 32'h7FFFFFFF);
				end
				5: begin
					mx = 5'd16;
					ttl = 32'd0;
					t = $urandom_range(0, 32'h7FFFFFFF);
				end
				6: begin
					// run into the top of the time range
					mx = $urandom_range(1, 16);
					ttl = $urandom();
					t = 32'hFFFFFF80;
				end
				7: begin
					mx = 5'd16;
					ttl = 32'd2000;
					t = $urandom();
				end
				8: begin
					mx = $urandom_range(0, 31);
					ttl = $urandom_range(0, 3000);
					t = $urandom_range(0, 32'h7FFFFFFF);
				end
				9: begin
					mx = 5'd1;
					ttl = 32'd100;
					t = 0;
				end
				default: begin
					mx = 5'd16;
					ttl = 32'd1000;
					t = 0;
				end
			endcase
			write_reg(CFG_ENABLE, CFG_DW'(en));
			write_reg(CFG_MAX, CFG_DW'(mx));
			write_reg(CFG_TTL, ttl);
			quiet = (ph % 3 == 2);
			for (int k = 0; k < POOL_SIZE; k++)
				pool[k] = $urandom_range(0, 65535);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3 && t > 50)
					t = t - $urandom_range(1, 50);
				else if (roll < 6)
					t = t + $urandom_range(1000, 100000);
				else
					t = t + $urandom_range(0, 30);
				if (t > {1'b0, {TIME_W{1'b1}}})
					t = {1'b0, {TIME_W{1'b1}}};
				op = ($urandom_range(0, 99) < 55) ? OP_STORE : OP_LOOKUP;
				if ($urandom_range(0, 99) < 85)
					key = pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					key = $urandom_range(0, 65535);
				send_word(op, key, t[TIME_W-1:0], 1'b0, 1'b0, '0);
			end
		end

		s_axis_tvalid = 1'b0;
		while (due_count != 0)
			@(negedge clk);
		// catch any stray result after the last one
		repeat (50) @(negedge clk);

		$display("run: %0d lookups and %0d stores under %0d register writes",
			lookups, stores, reg_writes);
		$display("run: %0d results checked, %0d hits, %0d mismatches",
			replies_seen, hits_seen, errors);
		if (errors == 0 && due_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
hw/rtl/tfkc_pkg.sv
hw/rtl/tfkc_ram.sv
hw/rtl/tfkc_walk.sv
hw/rtl/ttl_fifo_key_cache.sv
test/ttl_fifo_key_cache_test.sv
